/* design/cpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the cooling PWM ramp controller
// Field widths, register indexes, item kinds, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // field widths
    localparam int TEMP_W  = 16;
    localparam int DUTY_W  = 7;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;

    // inverter sum of three phases, and ramp arithmetic
    localparam int SUM_W   = TEMP_W + 2;
    localparam int NUM_W   = SUM_W + DUTY_W;
    localparam int SHIFT_W = SUM_W + DUTY_W - 1;

    // restoring divider: one quotient bit per step
    localparam int DIV_STEPS = DUTY_W;
    localparam int CNT_W     = 3;

    localparam logic [DUTY_W-1:0] FULL_DUTY        = 7'd100;
    localparam logic [DUTY_W-1:0] BATTERY_MAX_DUTY = 7'd75;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_INVERTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BATTERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEND     = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_INV_LOW   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_INV_HIGH  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_BAT_LOW   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BAT_HIGH  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_IDLE_FAN  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_IDLE_PUMP = 3'd5;
    localparam logic [CIDX_W-1:0] REG_IDLE_BAT  = 3'd6;
    localparam logic [CIDX_W-1:0] REG_INTERVAL  = 3'd7;

    // register reset values
    localparam logic [TEMP_W-1:0] RST_INV_LOW  = 16'd400;
    localparam logic [TEMP_W-1:0] RST_INV_HIGH = 16'd600;
    localparam logic [TEMP_W-1:0] RST_BAT_LOW  = 16'd2500;
    localparam logic [TEMP_W-1:0] RST_BAT_HIGH = 16'd4500;
    localparam logic [DUTY_W-1:0] RST_IDLE     = 7'd0;
    localparam logic [TEMP_W-1:0] RST_INTERVAL = 16'd500;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MULT,
        S_DIV,
        S_COMMIT,
        S_SEND
    } t_ctrl_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input beat
        logic eval;       // decide, write direct duties
        logic mult;       // form ramp numerator
        logic div_step;   // one restoring divide step
        logic commit;     // write divided duty
        logic send_load;  // load output register, stamp send time
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;   // ramp branch with nonzero span
        logic send_go;    // interval elapsed and queue has room
        logic out_free;   // output register can take a beat
    } t_dp_sts;

endpackage

/* design/cpr_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_intf: valid/ready channels of the cooling PWM ramp controller
// Input item channel, cooling command channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cpr_in_if;
    import cpr_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic                drive_active;
    logic [TEMP_W-1:0]   phase_a_raw;
    logic [TEMP_W-1:0]   phase_b_raw;
    logic [TEMP_W-1:0]   phase_c_raw;
    logic [TEMP_W-1:0]   battery_temp_raw;
    logic [TIME_W-1:0]   now_ms;
    logic                tx_space_free;

    modport source (
        output valid, kind, drive_active, phase_a_raw, phase_b_raw, phase_c_raw,
               battery_temp_raw, now_ms, tx_space_free,
        input  ready
    );
    modport sink (
        input  valid, kind, drive_active, phase_a_raw, phase_b_raw, phase_c_raw,
               battery_temp_raw, now_ms, tx_space_free,
        output ready
    );
endinterface

interface cpr_out_if;
    import cpr_pkg::*;
    logic                valid;
    logic                ready;
    logic                cooling_enable;
    logic [DUTY_W-1:0]   tractive_fan_duty;
    logic [DUTY_W-1:0]   tractive_pump_duty;
    logic [DUTY_W-1:0]   battery_fan_duty;

    modport source (
        output valid, cooling_enable, tractive_fan_duty, tractive_pump_duty,
               battery_fan_duty,
        input  ready
    );
    modport sink (
        input  valid, cooling_enable, tractive_fan_duty, tractive_pump_duty,
               battery_fan_duty,
        output ready
    );
endinterface

interface cpr_cfg_if;
    import cpr_pkg::*;
    logic                valid;
    logic                ready;
    logic [CIDX_W-1:0]   index;
    logic [CDATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/cpr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_dp: datapath of the cooling PWM ramp controller
// Holds configuration, duty state and send time, the threshold compares, the
// constant-scale multiply, a bit-serial restoring divider and the output
// register.
// ----------------------------------------------------------------------------
module cpr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpr_pkg::t_dp_cmd              i_cmd,
    output cpr_pkg::t_dp_sts              o_sts,
    input  logic [cpr_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_drive_active,
    input  logic [cpr_pkg::TEMP_W-1:0]    i_phase_a_raw,
    input  logic [cpr_pkg::TEMP_W-1:0]    i_phase_b_raw,
    input  logic [cpr_pkg::TEMP_W-1:0]    i_phase_c_raw,
    input  logic [cpr_pkg::TEMP_W-1:0]    i_battery_temp_raw,
    input  logic [cpr_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                          i_tx_space_free,
    cpr_cfg_if.sink                       i_cfg,
    cpr_out_if.source                     o_out
);
    import cpr_pkg::*;

    // configuration registers
    logic [TEMP_W-1:0] r_inv_low, r_inv_high, r_bat_low, r_bat_high, r_interval;
    logic [DUTY_W-1:0] r_idle_fan, r_idle_pump, r_idle_bat;

    // duty state and send stamp
    logic [DUTY_W-1:0] r_fan_now, r_pump_now, r_bat_now;
    logic [TIME_W-1:0] r_last_send;

    // captured beat
    logic [KIND_W-1:0] r_kind;
    logic              r_drive;
    logic [SUM_W-1:0]  r_sum;
    logic [TEMP_W-1:0] r_braw;
    logic [TIME_W-1:0] r_now;
    logic              r_space;

    // ramp operands and divider
    logic [SUM_W-1:0]   r_diff;
    logic [SUM_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_rem;
    logic [SHIFT_W-1:0] r_den_sh;
    logic [DUTY_W-1:0]  r_quo;

    // output register
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_fan, r_out_pump, r_out_bat;

    // evaluation signals
    logic [SUM_W-1:0]  lo3, hi3, inv_diff, inv_span;
    logic              inv_gt, inv_lt, inv_zero;
    logic [TEMP_W-1:0] bat_diff, bat_span;
    logic              bat_ge, bat_le;
    logic [TIME_W-1:0] elapsed;
    logic              is_inv, is_bat;
    logic              direct;
    logic [DUTY_W-1:0] direct_duty;
    logic [DUTY_W-1:0] scale;
    logic [NUM_W-1:0]  trial;
    logic              step_ge;

    assign i_cfg.ready = 1'b1;

    // thresholds times three, inverter compares
    assign lo3      = {2'b00, r_inv_low} + {1'b0, r_inv_low, 1'b0};
    assign hi3      = {2'b00, r_inv_high} + {1'b0, r_inv_high, 1'b0};
    assign inv_gt   = r_sum > hi3;
    assign inv_lt   = r_sum < lo3;
    assign inv_diff = r_sum - lo3;
    assign inv_span = hi3 - lo3;
    assign inv_zero = (inv_span == '0);

    // battery compares, inclusive at both ends
    assign bat_ge   = r_braw >= r_bat_high;
    assign bat_le   = r_braw <= r_bat_low;
    assign bat_diff = r_braw - r_bat_low;
    assign bat_span = r_bat_high - r_bat_low;

    assign elapsed = r_now - r_last_send;
    assign is_inv  = (r_kind == KIND_INVERTER);
    assign is_bat  = (r_kind == KIND_BATTERY);

    // pick the duty that needs no division
    always_comb begin
        direct      = 1'b1;
        direct_duty = '0;
        if (!r_drive) begin
            direct_duty = is_inv ? r_idle_fan : r_idle_bat;
        end else if (is_inv) begin
            if (inv_gt) begin
                direct_duty = FULL_DUTY;
            end else if (inv_lt || inv_zero) begin
                direct_duty = '0;
            end else begin
                direct = 1'b0;
            end
        end else begin
            if (bat_ge) begin
                direct_duty = BATTERY_MAX_DUTY;
            end else if (bat_le) begin
                direct_duty = '0;
            end else begin
                direct = 1'b0;
            end
        end
    end

    assign o_sts.need_div = (is_inv || is_bat) && !direct;
    assign o_sts.send_go  = (r_kind == KIND_SEND) && (elapsed >= {16'd0, r_interval})
                            && r_space;
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    assign scale   = is_inv ? FULL_DUTY : BATTERY_MAX_DUTY;
    assign trial   = {1'b0, r_den_sh};
    assign step_ge = r_rem >= trial;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_low   <= RST_INV_LOW;
            r_inv_high  <= RST_INV_HIGH;
            r_bat_low   <= RST_BAT_LOW;
            r_bat_high  <= RST_BAT_HIGH;
            r_idle_fan  <= RST_IDLE;
            r_idle_pump <= RST_IDLE;
            r_idle_bat  <= RST_IDLE;
            r_interval  <= RST_INTERVAL;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_INV_LOW:   r_inv_low   <= i_cfg.data;
                REG_INV_HIGH:  r_inv_high  <= i_cfg.data;
                REG_BAT_LOW:   r_bat_low   <= i_cfg.data;
                REG_BAT_HIGH:  r_bat_high  <= i_cfg.data;
                REG_IDLE_FAN:  r_idle_fan  <= i_cfg.data[DUTY_W-1:0];
                REG_IDLE_PUMP: r_idle_pump <= i_cfg.data[DUTY_W-1:0];
                REG_IDLE_BAT:  r_idle_bat  <= i_cfg.data[DUTY_W-1:0];
                REG_INTERVAL:  r_interval  <= i_cfg.data;
            endcase
        end
    end

    // capture beat, sum the three phases on the way in
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_drive <= i_drive_active;
            r_sum   <= {2'b00, i_phase_a_raw} + {2'b00, i_phase_b_raw}
                       + {2'b00, i_phase_c_raw};
            r_braw  <= i_battery_temp_raw;
            r_now   <= i_now_ms;
            r_space <= i_tx_space_free;
        end
    end

    // ramp operands, multiply, then one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_diff <= is_inv ? inv_diff : {2'b00, bat_diff};
            r_den  <= is_inv ? inv_span : {2'b00, bat_span};
        end
        if (i_cmd.mult) begin
            r_rem    <= NUM_W'(r_diff) * NUM_W'(scale);
            r_den_sh <= {r_den, {(DUTY_W-1){1'b0}}};
            r_quo    <= '0;
        end else if (i_cmd.div_step) begin
            if (step_ge) begin
                r_rem <= r_rem - trial;
            end
            r_den_sh <= r_den_sh >> 1;
            r_quo    <= {r_quo[DUTY_W-2:0], step_ge};
        end
    end

    // duty state and send stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_now   <= RST_IDLE;
            r_pump_now  <= RST_IDLE;
            r_bat_now   <= RST_IDLE;
            r_last_send <= '0;
        end else begin
            if (i_cmd.eval && direct && is_inv) begin
                r_fan_now  <= r_drive ? direct_duty : r_idle_fan;
                r_pump_now <= r_drive ? direct_duty : r_idle_pump;
            end
            if (i_cmd.eval && direct && is_bat) begin
                r_bat_now <= direct_duty;
            end
            if (i_cmd.commit && is_inv) begin
                r_fan_now  <= r_quo;
                r_pump_now <= r_quo;
            end
            if (i_cmd.commit && is_bat) begin
                r_bat_now <= r_quo;
            end
            if (i_cmd.send_load) begin
                r_last_send <= r_now;
            end
        end
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.send_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send_load) begin
            r_out_fan  <= r_fan_now;
            r_out_pump <= r_pump_now;
            r_out_bat  <= r_bat_now;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.cooling_enable     = 1'b1;
    assign o_out.tractive_fan_duty  = r_out_fan;
    assign o_out.tractive_pump_duty = r_out_pump;
    assign o_out.battery_fan_duty   = r_out_bat;

endmodule

/* design/cpr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ctrl: sequencer of the cooling PWM ramp controller
// Accepts one beat at a time, steps the datapath through evaluate, multiply,
// divide and commit, and waits for the output register on a send.
// ----------------------------------------------------------------------------
module cpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpr_pkg::t_dp_sts  i_sts,
    output cpr_pkg::t_dp_cmd  o_cmd
);
    import cpr_pkg::*;

    t_ctrl_state       r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.need_div) begin
                    n_state = S_MULT;
                end else if (i_sts.send_go) begin
                    n_state = S_SEND;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_cnt      = CNT_W'(DIV_STEPS - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.send_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EVAL))
        else $error("accepted beat did not move to evaluation");

    a_div_to_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_COMMIT))
        else $error("divider did not finish after its last step");

    a_send_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("send did not load a free output register");
`endif

endmodule

/* design/cooling_pwm_ramp_controller.sv */
// Sequence: a temperature beat writes its duties in the evaluate state when no
// ramp division is needed, else via multiply, the divide steps and the commit state.
// A send beat waits in the send state until the output register is free, then loads it.
// One beat at a time, taken in idle; ramp beats run the 7-step restoring divider.
// Reset: thresholds and interval take their defaults, duties and send time clear,
// no command is pending.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooling_pwm_ramp_controller: fan and pump duty ramps with rate-limited send
// Top level: joins the sequencer and the datapath to the item, command and
// configuration channels.
// ----------------------------------------------------------------------------
module cooling_pwm_ramp_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpr_in_if.sink      i_in,
    cpr_out_if.source   o_out,
    cpr_cfg_if.sink     i_cfg
);
    import cpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_in.ready = in_ready;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cpr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_kind             (i_in.kind),
        .i_drive_active     (i_in.drive_active),
        .i_phase_a_raw      (i_in.phase_a_raw),
        .i_phase_b_raw      (i_in.phase_b_raw),
        .i_phase_c_raw      (i_in.phase_c_raw),
        .i_battery_temp_raw (i_in.battery_temp_raw),
        .i_now_ms           (i_in.now_ms),
        .i_tx_space_free    (i_in.tx_space_free),
        .i_cfg              (i_cfg),
        .o_out              (o_out)
    );

endmodule
